@@ rtl/rphd_pkg.sv @@
// Shared types and constants for the raw profile hex decoder.
`default_nettype none

package rphd_pkg;

    localparam int LENGTH_BITS = 24;

    localparam logic [1:0] ST_DATA       = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_EARLY_END  = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last_of_profile;
    } result_t;

    // Classified character as handed from the front end to the back end.
    typedef struct packed {
        logic       eot;
        logic       is_nl;
        logic       is_space;
        logic       is_letter;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] nib;
    } token_t;

endpackage

`default_nettype wire

@@ rtl/rphd_front.sv @@
// Front end: classifies each text byte and queues the token for the back end.
`default_nettype none

module rphd_front
    import rphd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    output logic        full,
    input  wire item_t  item,
    output logic        tok_valid,
    output token_t      tok,
    input  wire logic   tok_pop
);

    token_t     tq_mem_reg [2];
    logic [1:0] tq_count_reg, tq_count_next;
    logic       tq_wr_reg, tq_rd_reg;
    logic       push_ok, pop_ok;
    token_t     cls;
    logic [7:0] c;

    assign c = item.text_byte;

    always_comb
    begin
        cls           = '0;
        cls.eot       = item.end_of_text;
        cls.is_nl     = (c == CH_NL);
        cls.is_space  = (c == CH_SPACE);
        cls.is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                        ((c >= CH_LO_A) && (c <= CH_LO_Z));
        cls.is_digit  = (c >= CH_0) && (c <= CH_9);
        if (cls.is_digit)
        begin
            cls.is_hex = 1'b1;
            cls.nib    = c[3:0];
        end
        else if ((c >= CH_LO_A) && (c <= CH_LO_F))
        begin
            // 'a' has low nibble 1, so adding 9 gives 10.
            cls.is_hex = 1'b1;
            cls.nib    = c[3:0] + 4'd9;
        end
    end

    assign full      = (tq_count_reg == 2'd2);
    assign tok_valid = (tq_count_reg != 2'd0);
    assign tok       = tq_mem_reg[tq_rd_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = tok_pop && tok_valid;

    always_comb
    begin
        tq_count_next = tq_count_reg;
        if (push_ok && !pop_ok)
            tq_count_next = tq_count_reg + 2'd1;
        else if (!push_ok && pop_ok)
            tq_count_next = tq_count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tq_count_reg <= 2'd0;
            tq_wr_reg    <= 1'b0;
            tq_rd_reg    <= 1'b0;
        end
        else
        begin
            tq_count_reg <= tq_count_next;
            if (push_ok)
                tq_wr_reg <= !tq_wr_reg;
            if (pop_ok)
                tq_rd_reg <= !tq_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            tq_mem_reg[tq_wr_reg] <= cls;
    end

endmodule

`default_nettype wire

@@ rtl/rphd_back.sv @@
// Back end: header and hex-pair state machine with its result queue.
`default_nettype none

module rphd_back
    import rphd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   tok_valid,
    input  wire token_t tok,
    output logic        tok_pop,
    output logic        empty,
    input  wire logic   pop,
    output result_t     result
);

    localparam logic [2:0] PH_NL1    = 3'd0;
    localparam logic [2:0] PH_ALPHA1 = 3'd1;
    localparam logic [2:0] PH_ALPHA  = 3'd2;
    localparam logic [2:0] PH_SPACE  = 3'd3;
    localparam logic [2:0] PH_DIGIT  = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_DRAIN  = 3'd6;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [2:0]             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [3:0]             hi_reg, hi_next;
    logic                   pend_reg, pend_next;

    logic [LENGTH_BITS+3:0] acc;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   produced;
    logic [7:0]             pair;
    logic                   res_valid;
    result_t                res;

    result_t    rq_mem_reg [2];
    logic [1:0] rq_count_reg, rq_count_next;
    logic       rq_wr_reg, rq_rd_reg;
    logic       rq_full, take, res_push, res_pop;

    assign rq_full = (rq_count_reg == 2'd2);
    assign take    = tok_valid && !rq_full;
    assign tok_pop = take;

    assign acc = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1) +
                 (LENGTH_BITS+4)'(tok.nib);
    assign left_dec = left_reg - LENGTH_BITS'(left_reg != '0);
    assign pair     = {hi_reg, tok.nib};
    assign produced = tok.is_hex && pend_reg;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        hi_next    = hi_reg;
        pend_next  = pend_reg;
        res_valid  = 1'b0;
        res        = '0;

        unique case (phase_reg)
            PH_NL1:
            begin
                if (tok.is_nl)
                    phase_next = PH_ALPHA1;
                else
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, ST_BAD_HEADER, 1'b1};
                end
            end
            PH_ALPHA1:
            begin
                if (tok.is_letter)
                    phase_next = PH_ALPHA;
                else
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, ST_BAD_HEADER, 1'b1};
                end
            end
            PH_ALPHA:
            begin
                if (tok.is_nl)
                    phase_next = PH_SPACE;
                else if (!tok.is_letter)
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, ST_BAD_HEADER, 1'b1};
                end
            end
            PH_SPACE:
            begin
                if (tok.is_digit)
                begin
                    len_next   = LENGTH_BITS'(tok.nib);
                    phase_next = PH_DIGIT;
                end
                else if (!tok.is_space)
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, ST_BAD_HEADER, 1'b1};
                end
            end
            PH_DIGIT:
            begin
                if (tok.is_digit)
                begin
                    // Overflow shows up as any bit set above the length width.
                    if (acc[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                    begin
                        len_next  = LEN_MAX;
                        res_valid = 1'b1;
                        res       = '{8'd0, ST_BAD_HEADER, 1'b1};
                    end
                    else
                        len_next = acc[LENGTH_BITS-1:0];
                end
                else if (tok.is_nl)
                begin
                    left_next = len_reg;
                    pend_next = 1'b0;
                    hi_next   = 4'd0;
                    if (len_reg == '0)
                    begin
                        res_valid = 1'b1;
                        res       = '{8'd0, ST_EMPTY, 1'b1};
                    end
                    else
                        phase_next = PH_DATA;
                end
                else
                begin
                    res_valid = 1'b1;
                    res       = '{8'd0, ST_BAD_HEADER, 1'b1};
                end
            end
            PH_DATA:
            begin
                if (tok.is_hex)
                begin
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        hi_next   = 4'd0;
                        left_next = left_dec;
                    end
                    else
                    begin
                        hi_next   = tok.nib;
                        pend_next = 1'b1;
                    end
                end
                if (produced && (left_dec == '0))
                begin
                    res_valid  = 1'b1;
                    res        = '{pair, ST_DATA, 1'b1};
                    phase_next = PH_DRAIN;
                end
                else if (tok.eot)
                begin
                    res_valid = 1'b1;
                    res       = '{(produced ? pair : 8'd0), ST_EARLY_END, 1'b1};
                end
                else if (produced)
                begin
                    res_valid = 1'b1;
                    res       = '{pair, ST_DATA, 1'b0};
                end
            end
            default:
            begin
            end
        endcase

        // Every result except a non-final data byte closes the profile.
        if (res_valid && res.last_of_profile)
            phase_next = PH_DRAIN;

        if (tok.eot)
        begin
            if (!res_valid && (phase_reg <= PH_DIGIT))
            begin
                res_valid = 1'b1;
                res       = '{8'd0, ST_EARLY_END, 1'b1};
            end
            phase_next = PH_NL1;
            pend_next  = 1'b0;
            hi_next    = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NL1;
            len_reg   <= '0;
            left_reg  <= '0;
            hi_reg    <= 4'd0;
            pend_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            hi_reg    <= hi_next;
            pend_reg  <= pend_next;
        end
    end

    // Result queue: two entries so a waiting result does not stop the next byte.
    assign res_push = take && res_valid;
    assign empty    = (rq_count_reg == 2'd0);
    assign res_pop  = pop && !empty;
    assign result   = rq_mem_reg[rq_rd_reg];

    always_comb
    begin
        rq_count_next = rq_count_reg;
        if (res_push && !res_pop)
            rq_count_next = rq_count_reg + 2'd1;
        else if (!res_push && res_pop)
            rq_count_next = rq_count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_count_reg <= 2'd0;
            rq_wr_reg    <= 1'b0;
            rq_rd_reg    <= 1'b0;
        end
        else
        begin
            rq_count_reg <= rq_count_next;
            if (res_push)
                rq_wr_reg <= !rq_wr_reg;
            if (res_pop)
                rq_rd_reg <= !rq_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            rq_mem_reg[rq_wr_reg] <= res;
    end

`ifndef NO_ASSERTIONS
    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count_reg != 2'd3)
        else $error("result queue count out of range");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res.status != ST_DATA) |-> res.last_of_profile)
        else $error("status result without last_of_profile");

    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && tok.eot |=> phase_reg == PH_NL1)
        else $error("end of text did not restart header parsing");

    a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res.status == ST_DATA) |-> phase_reg == PH_DATA)
        else $error("data byte produced outside the data phase");

    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> phase_reg == PH_DATA)
        else $error("nibble pending outside the data phase");
`endif

endmodule

`default_nettype wire

@@ rtl/raw_profile_hex_decoder_unit.sv @@
// Top level of the raw profile hex decoder.
// Accepts one profile text byte per cycle while full is low, yielding at most one
// result per byte. A byte accepted on push is classified and registered in a
// two-entry token queue; the back end takes it from there and registers its
// result in the result queue, from which it is then popped.
// The sustained rate is one byte per cycle while results are popped, set by
// the back-end state update, whose longest path is the times-ten-plus-digit length
// update and its overflow check. Each side stalls on its own: the token queue
// absorbs back-end stalls and a two-entry result queue absorbs a consumer that
// stops popping. Push is refused only while the token queue is full, which happens
// once the result queue has filled and the back end has stopped taking tokens;
// after a pop frees the result queue, full stays high until a token is taken.
`default_nettype none

module raw_profile_hex_decoder_unit
    import rphd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    logic   tok_valid;
    logic   tok_pop;
    token_t tok;

    rphd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    rphd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
